// ----- sv/bsb_pkg.sv -----
// Shared types and constants for the bit stream buffer.
package bsb_pkg;

	localparam int STORE_BYTES = 4096;
	localparam int MAX_BITS    = 64;

	localparam int POS_W  = 16;
	localparam int LEN_W  = 13;
	localparam int DATA_W = 64;
	localparam int CNT_W  = 7;

	// store is kept as 64-bit words split over an even and an odd bank
	localparam int WORD_W     = 64;
	localparam int OFF_W      = $clog2(WORD_W);
	localparam int BANK_DEPTH = STORE_BYTES / 16;
	localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int WORD_AW    = BANK_AW + 1;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_READ  = 2'd1,
		ACT_SEEK  = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	typedef struct packed {
		logic [OFF_W-1:0] offset;
		logic [CNT_W-1:0] count;
	} align_ctrl_t;

endpackage

// ----- sv/bit_stream_buffer.sv -----
// Bit stream buffer top level: cursor control, banked word store and result register.
//
// A bit-addressable store of STORE_BYTES bytes with a bit cursor. Each input word
// (in_valid/in_stall) carries one action: write 1..64 bits LSB-first at the cursor,
// read 1..64 bits from the cursor, seek the cursor (clamped to the valid bit count),
// or clear. Each action returns exactly one result word (out_valid/out_stall) with
// the read bits, a success flag, the cursor before and after, the valid bit count
// and the byte length.
// On accept the two store words are read into the bank read registers; stage 1
// merges and writes them back at the edge where the result register is also loaded.
// No action is accepted while one is in stage 1. An access spans at most two adjacent
// 64-bit words, held in an even and an odd bank, and the next action's read must
// follow the current write-back.
// Reset clears the cursor and counters; store contents are not cleared and are
// only read below the valid bit count, which is always written first. Clear acts
// the same way.
// A stalled result holds in the output register and in_stall stays high while it
// waits; the next action can be accepted at the edge where the result is taken.
module bit_stream_buffer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  action,
	input  logic [bsb_pkg::CNT_W-1:0]   bit_count,
	input  logic [bsb_pkg::DATA_W-1:0]  write_data,
	input  logic [bsb_pkg::POS_W-1:0]   new_position,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [bsb_pkg::DATA_W-1:0]  read_data,
	output logic                        ok,
	output logic [bsb_pkg::POS_W-1:0]   old_position,
	output logic [bsb_pkg::POS_W-1:0]   position,
	output logic [bsb_pkg::POS_W-1:0]   valid_bits,
	output logic [bsb_pkg::LEN_W-1:0]   length_bytes
);
	import bsb_pkg::*;

	localparam logic [POS_W:0] STORE_BYTES_X = (POS_W+1)'(STORE_BYTES);
	localparam logic [CNT_W-1:0] MAX_CNT    = CNT_W'(MAX_BITS);

	// architectural state
	logic [POS_W-1:0] cursor_q;
	logic [POS_W-1:0] total_q;
	logic [LEN_W-1:0] bytes_q;

	// stage 1: store access
	logic              valid_s1;
	logic              wr_s1;
	logic              rd_s1;
	logic              ok_s1;
	align_ctrl_t       ctrl_s1;
	logic [DATA_W-1:0] wdata_s1;
	logic              odd_s1;
	logic [BANK_AW-1:0] even_addr_s1;
	logic [BANK_AW-1:0] odd_addr_s1;
	logic [POS_W-1:0]  old_s1;
	logic [POS_W-1:0]  pos_s1;
	logic [POS_W-1:0]  total_s1;
	logic [LEN_W-1:0]  bytes_s1;

	// result register
	logic              out_valid_q;
	logic [DATA_W-1:0] read_data_q;
	logic              ok_q;
	logic [POS_W-1:0]  old_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  total_q_out;
	logic [LEN_W-1:0]  bytes_q_out;

	action_t           act;
	logic              in_fire;
	logic              out_fire;
	logic              cnt_ok;
	logic [POS_W:0]    end_bits;
	logic [POS_W:0]    end_bytes;
	logic              wr_ok;
	logic              rd_ok;
	logic [POS_W-1:0]  nxt_cursor;
	logic [POS_W-1:0]  nxt_total;
	logic [LEN_W-1:0]  nxt_bytes;
	logic              nxt_ok;
	logic [WORD_AW-1:0] word_idx;
	logic [WORD_AW-1:0] word_nxt;
	logic [BANK_AW-1:0] even_addr;
	logic [BANK_AW-1:0] odd_addr;

	logic [WORD_W-1:0] even_rdata;
	logic [WORD_W-1:0] odd_rdata;
	logic [WORD_W-1:0] lo_word;
	logic [WORD_W-1:0] hi_word;
	logic [WORD_W-1:0] new_lo;
	logic [WORD_W-1:0] new_hi;
	logic              lo_wen;
	logic              hi_wen;
	logic [DATA_W-1:0] al_read;
	logic              even_we;
	logic              odd_we;
	logic [WORD_W-1:0] even_wdata;
	logic [WORD_W-1:0] odd_wdata;

	assign act      = action_t'(action);
	assign in_stall = valid_s1 | (out_valid_q & out_stall);
	assign in_fire  = in_valid & ~in_stall;
	assign out_fire = out_valid_q & ~out_stall;

	// bounds and next state, all from the current cursor
	always_comb begin
		cnt_ok    = (bit_count != '0) && (bit_count <= MAX_CNT);
		end_bits  = {1'b0, cursor_q} + {{(POS_W+1-CNT_W){1'b0}}, bit_count};
		end_bytes = (end_bits + (POS_W+1)'(7)) >> 3;
		wr_ok     = 1'b0;
		rd_ok     = 1'b0;
		nxt_cursor = cursor_q;
		nxt_total  = total_q;
		nxt_bytes  = bytes_q;
		nxt_ok     = 1'b1;
		case (act)
			ACT_WRITE: begin
				wr_ok  = cnt_ok && (end_bytes <= STORE_BYTES_X);
				nxt_ok = wr_ok;
				if (wr_ok) begin
					nxt_cursor = end_bits[POS_W-1:0];
					nxt_bytes  = end_bytes[LEN_W-1:0];
					if (end_bits[POS_W-1:0] > total_q) begin
						nxt_total = end_bits[POS_W-1:0];
					end
				end
			end
			ACT_READ: begin
				rd_ok  = cnt_ok && (end_bits <= {1'b0, total_q});
				nxt_ok = rd_ok;
				if (rd_ok) begin
					nxt_cursor = end_bits[POS_W-1:0];
				end
			end
			ACT_SEEK: begin
				nxt_cursor = (new_position < total_q) ? new_position : total_q;
			end
			ACT_CLEAR: begin
				nxt_cursor = '0;
				nxt_total  = '0;
				nxt_bytes  = '0;
			end
			default: begin
				nxt_ok = 1'b0;
			end
		endcase
	end

	// word w holds the first bit; w+1 may hold the rest, in the other bank
	assign word_idx  = cursor_q[OFF_W +: WORD_AW];
	assign word_nxt  = word_idx + WORD_AW'(1);
	assign even_addr = word_nxt[WORD_AW-1:1];
	assign odd_addr  = word_idx[WORD_AW-1:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			total_q  <= '0;
			bytes_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire;
			if (in_fire) begin
				cursor_q <= nxt_cursor;
				total_q  <= nxt_total;
				bytes_q  <= nxt_bytes;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			wr_s1          <= wr_ok;
			rd_s1          <= rd_ok;
			ok_s1          <= nxt_ok;
			ctrl_s1.offset <= cursor_q[OFF_W-1:0];
			ctrl_s1.count  <= bit_count;
			wdata_s1       <= write_data;
			odd_s1         <= word_idx[0];
			even_addr_s1   <= even_addr;
			odd_addr_s1    <= odd_addr;
			old_s1         <= cursor_q;
			pos_s1         <= nxt_cursor;
			total_s1       <= nxt_total;
			bytes_s1       <= nxt_bytes;
		end
	end

	bsb_ram #(.DEPTH(BANK_DEPTH), .WIDTH(WORD_W), .AW(BANK_AW)) u_even (
		.clk   (clk),
		.we    (even_we),
		.waddr (even_addr_s1),
		.wdata (even_wdata),
		.re    (in_fire),
		.raddr (even_addr),
		.rdata (even_rdata)
	);

	bsb_ram #(.DEPTH(BANK_DEPTH), .WIDTH(WORD_W), .AW(BANK_AW)) u_odd (
		.clk   (clk),
		.we    (odd_we),
		.waddr (odd_addr_s1),
		.wdata (odd_wdata),
		.re    (in_fire),
		.raddr (odd_addr),
		.rdata (odd_rdata)
	);

	assign lo_word = odd_s1 ? odd_rdata : even_rdata;
	assign hi_word = odd_s1 ? even_rdata : odd_rdata;

	bsb_align u_align (
		.ctrl       (ctrl_s1),
		.lo_word    (lo_word),
		.hi_word    (hi_word),
		.write_data (wdata_s1),
		.read_data  (al_read),
		.new_lo     (new_lo),
		.new_hi     (new_hi),
		.lo_wen     (lo_wen),
		.hi_wen     (hi_wen)
	);

	assign even_wdata = odd_s1 ? new_hi : new_lo;
	assign odd_wdata  = odd_s1 ? new_lo : new_hi;
	assign even_we    = valid_s1 & wr_s1 & (odd_s1 ? hi_wen : lo_wen);
	assign odd_we     = valid_s1 & wr_s1 & (odd_s1 ? lo_wen : hi_wen);

	// output register is always free when stage 1 completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			read_data_q <= rd_s1 ? al_read : '0;
			ok_q        <= ok_s1;
			old_q       <= old_s1;
			pos_q       <= pos_s1;
			total_q_out <= total_s1;
			bytes_q_out <= bytes_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign read_data    = read_data_q;
	assign ok           = ok_q;
	assign old_position = old_q;
	assign position     = pos_q;
	assign valid_bits   = total_q_out;
	assign length_bytes = bytes_q_out;

endmodule

// ----- sv/bsb_ram.sv -----
// Single-port-write, single-port-read synchronous RAM with registered read data.
module bsb_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/bsb_align.sv -----
// Bit alignment: extracts a field from two adjacent words and merges new bits into them.
module bsb_align (
	input  bsb_pkg::align_ctrl_t             ctrl,
	input  logic [bsb_pkg::WORD_W-1:0]       lo_word,
	input  logic [bsb_pkg::WORD_W-1:0]       hi_word,
	input  logic [bsb_pkg::DATA_W-1:0]       write_data,
	output logic [bsb_pkg::DATA_W-1:0]       read_data,
	output logic [bsb_pkg::WORD_W-1:0]       new_lo,
	output logic [bsb_pkg::WORD_W-1:0]       new_hi,
	output logic                             lo_wen,
	output logic                             hi_wen
);
	import bsb_pkg::*;

	logic [DATA_W-1:0]   nmask;
	logic [2*WORD_W-1:0] window;
	logic [2*WORD_W-1:0] rd_shift;
	logic [2*WORD_W-1:0] wmask;
	logic [2*WORD_W-1:0] ins;
	logic [2*WORD_W-1:0] merged;

	always_comb begin
		// shift by 64 yields zero, so a full-width count gives all ones
		nmask    = ~({DATA_W{1'b1}} << ctrl.count);
		window   = {hi_word, lo_word};
		rd_shift = window >> ctrl.offset;
		wmask    = {{(2*WORD_W-DATA_W){1'b0}}, nmask} << ctrl.offset;
		ins      = {{(2*WORD_W-DATA_W){1'b0}}, write_data & nmask} << ctrl.offset;
		merged   = (window & ~wmask) | ins;
	end

	assign read_data = rd_shift[DATA_W-1:0] & nmask;
	assign new_lo    = merged[WORD_W-1:0];
	assign new_hi    = merged[2*WORD_W-1:WORD_W];
	assign lo_wen    = |wmask[WORD_W-1:0];
	assign hi_wen    = |wmask[2*WORD_W-1:WORD_W];

endmodule

// ----- sv/bsb_checker.sv -----
// Port-level checks for the bit stream buffer, bound to the top level.
module bsb_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic                        ok,
	input logic [bsb_pkg::DATA_W-1:0]  read_data,
	input logic [bsb_pkg::POS_W-1:0]   position,
	input logic [bsb_pkg::POS_W-1:0]   valid_bits
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// one word at a time: nothing is taken right after an accept
	a_in_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted in back-to-back cycles");

	// a failed action returns no data
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> read_data == '0)
		else $error("failed action returned data");

	// cursor never passes the valid content
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> position <= valid_bits)
		else $error("cursor beyond valid bits");

endmodule

bind bit_stream_buffer bsb_checker u_bsb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.ok         (ok),
	.read_data  (read_data),
	.position   (position),
	.valid_bits (valid_bits)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the bit stream buffer: random and directed actions vs a predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import bsb_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [DATA_W-1:0] rd;
		logic              ok;
		logic [POS_W-1:0]  old_pos;
		logic [POS_W-1:0]  pos;
		logic [POS_W-1:0]  total;
		logic [LEN_W-1:0]  len;
	} stream_result_t;

	// tracks the stream state and the results still owed by the block
	class stream_tracker;
		bit [7:0]       bytes [STORE_BYTES];
		int unsigned    cur;
		int unsigned    total;
		int unsigned    len_b;
		stream_result_t pending_results [$];
		int             errors;

		task report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
			$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
			errors++;
		endtask

		function void take_word(action_t act, logic [CNT_W-1:0] n, logic [DATA_W-1:0] data,
				logic [POS_W-1:0] req);
			stream_result_t r;
			int unsigned    fin;
			int unsigned    fin_bytes;
			int unsigned    a;
			r = '0;
			r.old_pos = POS_W'(cur);
			case (act)
				ACT_WRITE: begin
					if (n >= 1 && n <= MAX_BITS) begin
						fin = cur + n;
						fin_bytes = (fin + 7) >> 3;
						if (fin_bytes <= STORE_BYTES) begin
							for (int i = 0; i < n; i++) begin
								a = cur + i;
								bytes[a >> 3][a[2:0]] = data[i];
							end
							cur = fin;
							len_b = fin_bytes;
							if (cur > total)
								total = cur;
							r.ok = 1'b1;
						end
					end
				end
				ACT_READ: begin
					if (n >= 1 && n <= MAX_BITS && cur + n <= total) begin
						for (int i = 0; i < n; i++) begin
							a = cur + i;
							r.rd[i] = bytes[a >> 3][a[2:0]];
						end
						cur += n;
						r.ok = 1'b1;
					end
				end
				ACT_SEEK: begin
					cur = (req < total) ? req : total;
					r.ok = 1'b1;
				end
				default: begin
					cur = 0;
					total = 0;
					len_b = 0;
					r.ok = 1'b1;
				end
			endcase
			r.pos = POS_W'(cur);
			r.total = POS_W'(total);
			r.len = LEN_W'(len_b);
			pending_results.push_back(r);
		endfunction

		task check_result(stream_result_t got);
			stream_result_t want;
			if (pending_results.size() == 0) begin
				report("unexpected word", DATA_W'(got.pos), '0);
			end else begin
				want = pending_results.pop_front();
				if (got.rd !== want.rd)
					report("read_data", got.rd, want.rd);
				if (got.ok !== want.ok)
					report("ok", DATA_W'(got.ok), DATA_W'(want.ok));
				if (got.old_pos !== want.old_pos)
					report("old_position", DATA_W'(got.old_pos), DATA_W'(want.old_pos));
				if (got.pos !== want.pos)
					report("position", DATA_W'(got.pos), DATA_W'(want.pos));
				if (got.total !== want.total)
					report("valid_bits", DATA_W'(got.total), DATA_W'(want.total));
				if (got.len !== want.len)
					report("length_bytes", DATA_W'(got.len), DATA_W'(want.len));
			end
		endtask
	endclass

	logic              clk;
	logic              arst_n       = 1'b0;
	logic              in_valid     = 1'b0;
	logic              in_stall;
	logic [1:0]        action       = ACT_WRITE;
	logic [CNT_W-1:0]  bit_count    = '0;
	logic [DATA_W-1:0] write_data   = '0;
	logic [POS_W-1:0]  new_position = '0;
	logic              out_valid;
	logic              out_stall    = 1'b0;
	logic [DATA_W-1:0] read_data;
	logic              ok;
	logic [POS_W-1:0]  old_position;
	logic [POS_W-1:0]  position;
	logic [POS_W-1:0]  valid_bits;
	logic [LEN_W-1:0]  length_bytes;

	stream_tracker sb = new();
	bit            steady = 1'b0;
	int            cycles = 0;

	bit_stream_buffer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.bit_count    (bit_count),
		.write_data   (write_data),
		.new_position (new_position),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_data    (read_data),
		.ok           (ok),
		.old_position (old_position),
		.position     (position),
		.valid_bits   (valid_bits),
		.length_bytes (length_bytes)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			out_stall <= !steady && ($urandom_range(0, 99) < 15);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{read_data, ok, old_position, position, valid_bits, length_bytes});
	end

	task automatic send_word(action_t act, logic [CNT_W-1:0] n, logic [DATA_W-1:0] data,
			logic [POS_W-1:0] req);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 15) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		bit_count <= n;
		write_data <= data;
		new_position <= req;
		do
			@(posedge clk);
		while (in_stall);
		sb.take_word(act, n, data, req);
	endtask

	function automatic logic [DATA_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// seek somewhere inside the stream, now and then anywhere in the 16-bit range
	task automatic seek_somewhere();
		int unsigned k;
		k = $urandom_range(0, 99);
		if (k < 70)
			send_word(ACT_SEEK, CNT_W'($urandom), rand64(),
				POS_W'($urandom_range(0, sb.total)));
		else if (k < 90)
			send_word(ACT_SEEK, CNT_W'($urandom), rand64(), POS_W'($urandom));
		else
			send_word(ACT_SEEK, CNT_W'($urandom), rand64(), POS_W'(sb.total));
	endtask

	task automatic random_action();
		int unsigned k;
		int unsigned room;
		logic [CNT_W-1:0] n;
		action_t bad_act;
		k = $urandom_range(0, 99);
		if (k < 40) begin
			send_word(ACT_WRITE, CNT_W'($urandom_range(1, MAX_BITS)), rand64(),
				POS_W'($urandom));
		end else if (k < 72) begin
			if ($urandom_range(0, 1))
				seek_somewhere();
			room = sb.total - sb.cur;
			if (room > 0 && $urandom_range(0, 99) < 85)
				n = CNT_W'($urandom_range(1, (room < MAX_BITS) ? room : MAX_BITS));
			else
				n = CNT_W'($urandom_range(1, MAX_BITS));
			send_word(ACT_READ, n, rand64(), POS_W'($urandom));
		end else if (k < 88) begin
			seek_somewhere();
		end else if (k < 91) begin
			send_word(ACT_CLEAR, CNT_W'($urandom), rand64(), POS_W'($urandom));
		end else begin
			// out-of-range bit count
			n = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(MAX_BITS + 1, 127));
			if ($urandom_range(0, 1))
				bad_act = ACT_WRITE;
			else
				bad_act = ACT_READ;
			send_word(bad_act, n, rand64(), POS_W'($urandom));
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty stream, then a few writes and reads across byte and word edges
		send_word(ACT_READ, 7'd1, '0, '0);
		send_word(ACT_SEEK, 7'd0, '0, 16'd100);
		send_word(ACT_WRITE, 7'd64, '1, '0);
		send_word(ACT_WRITE, 7'd1, '0, '0);
		send_word(ACT_WRITE, 7'd7, 64'h55, '0);
		send_word(ACT_SEEK, 7'd0, '0, 16'd3);
		send_word(ACT_READ, 7'd64, '0, '0);
		send_word(ACT_READ, 7'd64, '0, '0);
		send_word(ACT_READ, 7'd5, '0, '0);
		send_word(ACT_SEEK, 7'd0, '0, 16'hffff);
		send_word(ACT_WRITE, 7'd0, '1, '0);
		send_word(ACT_WRITE, 7'd127, '1, '0);
		send_word(ACT_READ, 7'd0, '0, '0);
		send_word(ACT_READ, 7'd65, '0, '0);
		// a short write after seeking back shrinks the byte length
		send_word(ACT_SEEK, 7'd0, '0, 16'd0);
		send_word(ACT_WRITE, 7'd3, 64'h2, '0);
		send_word(ACT_READ, 7'd64, '0, '0);
		send_word(ACT_WRITE, 7'd64, 64'haaaa_aaaa_aaaa_aaaa, '0);
		send_word(ACT_SEEK, 7'd127, '1, 16'd9);
		send_word(ACT_READ, 7'd64, '0, '1);
		send_word(ACT_CLEAR, '1, '1, '1);
		send_word(ACT_READ, 7'd1, '0, '0);
		send_word(ACT_WRITE, 7'd1, '1, '0);
		send_word(ACT_SEEK, 7'd0, '0, 16'd0);
		send_word(ACT_READ, 7'd1, '0, '0);

		repeat (250)
			random_action();

		// fill the whole store, the first half with no gaps on either side
		send_word(ACT_CLEAR, '0, '0, '0);
		steady = 1'b1;
		for (int i = 0; i < STORE_BYTES / 8; i++) begin
			if (i == STORE_BYTES / 16)
				steady = 1'b0;
			send_word(ACT_WRITE, 7'd64, rand64(), POS_W'($urandom));
		end
		send_word(ACT_WRITE, 7'd1, '1, '0);
		send_word(ACT_SEEK, 7'd0, '0, 16'(STORE_BYTES * 8 - 8));
		send_word(ACT_WRITE, 7'd9, '1, '0);
		send_word(ACT_WRITE, 7'd8, 64'h3c, '0);
		send_word(ACT_READ, 7'd1, '0, '0);
		send_word(ACT_SEEK, 7'd0, '0, 16'(STORE_BYTES * 8 - 64));
		send_word(ACT_READ, 7'd64, '0, '0);
		for (int i = 0; i < 60; i++) begin
			send_word(ACT_SEEK, 7'd0, '0, POS_W'($urandom_range(0, STORE_BYTES * 8)));
			send_word(ACT_READ, CNT_W'($urandom_range(1, MAX_BITS)), rand64(), '0);
		end

		repeat (250)
			random_action();

		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end
endmodule

// ----- filelist.f -----
sv/bsb_pkg.sv
sv/bsb_ram.sv
sv/bsb_align.sv
sv/bit_stream_buffer.sv
sv/bsb_checker.sv
tb/tb_top.sv
